>>> sv/bavg_pkg.sv
// Shared constants, command/status types and helper functions for the
// block average downscaler. No dependencies.
package bavg_pkg;

    localparam int MAX_SRC_DIM = 4096;
    localparam int MAX_OUT_DIM = 1024;
    localparam int DIV_STEPS   = 32;

    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_SRC_WIDTH  = 3'd1;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd2;
    localparam logic [2:0] REG_BLOCK_SIZE = 3'd3;
    localparam logic [2:0] REG_OUT_WIDTH  = 3'd4;
    localparam logic [2:0] REG_OUT_HEIGHT = 3'd5;

    localparam logic [1:0] DIV_COL = 2'd0;
    localparam logic [1:0] DIV_ROW = 2'd1;
    localparam logic [1:0] DIV_AVG = 2'd2;

    localparam logic [7:0] ALPHA = 8'hFF;

    typedef struct packed {
        logic       div_start;
        logic [1:0] div_sel;
        logic       load_col;
        logic       load_row;
        logic       restart;
        logic       step;
        logic       acc;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic cfg_hit;
        logic div_done;
        logic emit;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [12:0] pos;
        logic [10:0] acc;
    } bound_t;

    function automatic logic [12:0] clamp_src(input logic [12:0] v);
        logic [12:0] r;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (v > 13'(MAX_SRC_DIM)) begin
            r = 13'(MAX_SRC_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [10:0] clamp_out(input logic [12:0] v);
        logic [10:0] r;
        if (v == 13'd0) begin
            r = 11'd1;
        end else if (v > 13'(MAX_OUT_DIM)) begin
            r = 11'(MAX_OUT_DIM);
        end else begin
            r = v[10:0];
        end
        return r;
    endfunction

    // End of the following region, stepping the fractional remainder in target mode
    function automatic bound_t next_bound(input logic [12:0] pos, input logic [10:0] acc,
                                          input logic [12:0] inc, input logic [10:0] rem,
                                          input logic [10:0] dvs, input logic [12:0] lim,
                                          input logic tgt);
        logic [11:0] t;
        logic        carry;
        logic [13:0] s;
        bound_t      r;
        t     = {1'b0, acc} + {1'b0, rem};
        carry = tgt && (t >= {1'b0, dvs});
        s     = {1'b0, pos} + {1'b0, inc} + {13'd0, carry};
        r.acc = carry ? 11'(t - {1'b0, dvs}) : t[10:0];
        r.pos = (s > {1'b0, lim}) ? lim : s[12:0];
        return r;
    endfunction

endpackage

>>> sv/block_average_downscaler_unit.sv
// Top level of the block average downscaler: controller plus datapath.
// Depends on bavg_pkg, bavg_ctrl and bavg_datapath.
//
// Area-average downscaler for a raster pixel stream. Each source pixel goes
// through a column sum read, then an add and write back in the 1024-entry sum
// memory; a pixel that closes a region adds a bit-serial division for the
// three colour averages plus the hand-off to the output register. After
// reset and after every register write the block runs two setup divisions
// for the region boundaries and takes no pixels meanwhile. Results sit in
// an output register, so the next pixel is taken while a result waits.
module block_average_downscaler_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_pixel,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_avg_pixel,
    output logic [9:0]  m_out_col,
    output logic [9:0]  m_out_row,
    output logic        m_frame_done
);

    bavg_pkg::cmd_t cmd;
    bavg_pkg::sts_t sts;

    bavg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bavg_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_pixel       (s_pixel),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_avg_pixel   (m_avg_pixel),
        .m_out_col     (m_out_col),
        .m_out_row     (m_out_row),
        .m_frame_done  (m_frame_done),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

>>> sv/bavg_div.sv
// Three-lane restoring divider, one quotient bit per cycle per lane.
// Depends on bavg_pkg.
module bavg_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [2:0][31:0]  dividend,
    input  logic [24:0]       divisor,
    output logic              done,
    output logic [2:0][31:0]  quotient,
    output logic [24:0]       remainder
);

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [24:0]       dvs_reg;
    logic [2:0][31:0]  quo_reg;
    logic [2:0][24:0]  rem_reg;
    logic [2:0][31:0]  quo_next;
    logic [2:0][24:0]  rem_next;

    always_comb begin
        logic [25:0] trial;
        logic        ge;
        for (int i = 0; i < 3; i++) begin
            trial       = {rem_reg[i], quo_reg[i][31]};
            ge          = trial >= {1'b0, dvs_reg};
            rem_next[i] = ge ? 25'(trial - {1'b0, dvs_reg}) : trial[24:0];
            quo_next[i] = {quo_reg[i][30:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(bavg_pkg::DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvs_reg <= divisor;
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[0];

endmodule

>>> sv/bavg_datapath.sv
// Datapath: registers, region tracking, column sum memory, divider and
// output register. Depends on bavg_pkg and bavg_div.
module bavg_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [12:0]          cfg_data,
    input  logic [31:0]          s_pixel,
    input  logic                 s_frame_start,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_avg_pixel,
    output logic [9:0]           m_out_col,
    output logic [9:0]           m_out_row,
    output logic                 m_frame_done,
    input  bavg_pkg::cmd_t       cmd,
    output bavg_pkg::sts_t       sts
);

    logic        mode_reg;
    logic [12:0] src_w_reg, src_h_reg, blk_reg;
    logic [10:0] out_w_reg, out_h_reg;

    logic [12:0] sw, sh, bsz;
    logic [10:0] tw_t, th_t, ow_c, oh_c;

    logic [12:0] col_inc_reg, row_inc_reg, col_first_reg, row_first_reg;
    logic [10:0] col_rem_reg, row_rem_reg, col_dvs_reg, row_dvs_reg;
    logic [10:0] col_n_reg, row_n_reg;

    logic [11:0] x_reg, y_reg, x_next, y_next, x_e, y_e;
    logic [10:0] rc_reg, rr_reg, rc_next, rr_next, rc_e, rr_e;
    logic [12:0] cs_reg, cb_reg, rs_reg, rb_reg;
    logic [12:0] cs_next, cb_next, rs_next, rb_next;
    logic [12:0] cs_e, cb_e, rs_e, rb_e;
    logic [10:0] ca_reg, ra_reg, ca_next, ra_next, ca_e, ra_e;

    logic        fs, active, col_hit, row_hit, x_last, y_last;
    logic [12:0] x_inc, y_inc, w_cur, h_cur;
    logic [25:0] cnt_full;
    bavg_pkg::bound_t nb_c, nb_r;

    logic [95:0] sums_mem [bavg_pkg::MAX_OUT_DIM];
    logic [95:0] rd_reg;
    logic [9:0]  addr_reg;
    logic        zero_reg, act_reg, emit_reg, odone_reg;
    logic [7:0]  r_reg, g_reg, b_reg;
    logic [24:0] cnt_reg;
    logic [9:0]  ocol_reg, orow_reg;
    logic [31:0] sum_r, sum_g, sum_b;

    logic [2:0][31:0] dvd;
    logic [24:0]      dvs;
    logic             div_done;
    logic [2:0][31:0] quo;
    logic [24:0]      rem0;
    logic [12:0]      q13;

    logic        m_valid_reg, odn_reg;
    logic [31:0] avg_reg;
    logic [9:0]  col_out_reg, row_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            src_w_reg <= 13'd1;
            src_h_reg <= 13'd1;
            blk_reg   <= 13'd1;
            out_w_reg <= 11'd1;
            out_h_reg <= 11'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                bavg_pkg::REG_MODE:       mode_reg  <= cfg_data[0];
                bavg_pkg::REG_SRC_WIDTH:  src_w_reg <= cfg_data;
                bavg_pkg::REG_SRC_HEIGHT: src_h_reg <= cfg_data;
                bavg_pkg::REG_BLOCK_SIZE: blk_reg   <= cfg_data;
                bavg_pkg::REG_OUT_WIDTH:  out_w_reg <= cfg_data[10:0];
                bavg_pkg::REG_OUT_HEIGHT: out_h_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign sw   = bavg_pkg::clamp_src(src_w_reg);
    assign sh   = bavg_pkg::clamp_src(src_h_reg);
    assign bsz  = (blk_reg == 13'd0) ? 13'd1 : blk_reg;
    assign ow_c = bavg_pkg::clamp_out({2'b00, out_w_reg});
    assign oh_c = bavg_pkg::clamp_out({2'b00, out_h_reg});
    assign tw_t = ({2'b00, ow_c} > sw) ? sw[10:0] : ow_c;
    assign th_t = ({2'b00, oh_c} > sh) ? sh[10:0] : oh_c;

    always_comb begin
        dvd[1] = sum_g;
        dvd[2] = sum_b;
        if (cmd.div_sel == bavg_pkg::DIV_AVG) begin
            dvd[0] = sum_r;
            dvs    = cnt_reg;
        end else if (cmd.div_sel == bavg_pkg::DIV_COL) begin
            dvd[0] = {19'd0, sw};
            dvs    = mode_reg ? {14'd0, tw_t} : {12'd0, bsz};
        end else begin
            dvd[0] = {19'd0, sh};
            dvs    = mode_reg ? {14'd0, th_t} : {12'd0, bsz};
        end
    end

    bavg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (dvd),
        .divisor   (dvs),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem0)
    );

    assign q13 = quo[0][12:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_col) begin
            col_n_reg     <= mode_reg ? tw_t : bavg_pkg::clamp_out(q13);
            col_inc_reg   <= mode_reg ? q13 : bsz;
            col_rem_reg   <= mode_reg ? rem0[10:0] : 11'd0;
            col_dvs_reg   <= tw_t;
            col_first_reg <= mode_reg ? q13 : ((bsz < sw) ? bsz : sw);
        end
        if (cmd.load_row) begin
            row_n_reg     <= mode_reg ? th_t : bavg_pkg::clamp_out(q13);
            row_inc_reg   <= mode_reg ? q13 : bsz;
            row_rem_reg   <= mode_reg ? rem0[10:0] : 11'd0;
            row_dvs_reg   <= th_t;
            row_first_reg <= mode_reg ? q13 : ((bsz < sh) ? bsz : sh);
        end
    end

    assign fs   = cmd.step && s_frame_start;
    assign x_e  = fs ? 12'd0 : x_reg;
    assign y_e  = fs ? 12'd0 : y_reg;
    assign rc_e = fs ? 11'd0 : rc_reg;
    assign rr_e = fs ? 11'd0 : rr_reg;
    assign cs_e = fs ? 13'd0 : cs_reg;
    assign rs_e = fs ? 13'd0 : rs_reg;
    assign cb_e = fs ? col_first_reg : cb_reg;
    assign rb_e = fs ? row_first_reg : rb_reg;
    assign ca_e = fs ? col_rem_reg : ca_reg;
    assign ra_e = fs ? row_rem_reg : ra_reg;

    assign x_inc   = {1'b0, x_e} + 13'd1;
    assign y_inc   = {1'b0, y_e} + 13'd1;
    assign active  = (rr_e < row_n_reg) && (rc_e < col_n_reg);
    assign col_hit = x_inc >= cb_e;
    assign row_hit = y_inc >= rb_e;
    assign x_last  = x_inc >= sw;
    assign y_last  = y_inc >= sh;
    assign nb_c    = bavg_pkg::next_bound(cb_e, ca_e, col_inc_reg, col_rem_reg,
                                          col_dvs_reg, sw, mode_reg);
    assign nb_r    = bavg_pkg::next_bound(rb_e, ra_e, row_inc_reg, row_rem_reg,
                                          row_dvs_reg, sh, mode_reg);
    assign w_cur    = cb_e - cs_e;
    assign h_cur    = rb_e - rs_e;
    assign cnt_full = {13'd0, w_cur} * {13'd0, h_cur};

    always_comb begin
        x_next  = x_reg;
        y_next  = y_reg;
        rc_next = rc_reg;
        rr_next = rr_reg;
        cs_next = cs_reg;
        cb_next = cb_reg;
        ca_next = ca_reg;
        rs_next = rs_reg;
        rb_next = rb_reg;
        ra_next = ra_reg;
        if (cmd.restart) begin
            x_next  = '0;
            y_next  = '0;
            rc_next = '0;
            rr_next = '0;
            cs_next = '0;
            cb_next = col_first_reg;
            ca_next = col_rem_reg;
            rs_next = '0;
            rb_next = row_first_reg;
            ra_next = row_rem_reg;
        end else if (cmd.step) begin
            y_next  = y_e;
            rc_next = rc_e;
            rr_next = rr_e;
            cs_next = cs_e;
            cb_next = cb_e;
            ca_next = ca_e;
            rs_next = rs_e;
            rb_next = rb_e;
            ra_next = ra_e;
            if (active && col_hit) begin
                rc_next = rc_e + 11'd1;
                cs_next = cb_e;
                cb_next = nb_c.pos;
                ca_next = nb_c.acc;
            end
            if (x_last) begin
                x_next  = '0;
                rc_next = '0;
                cs_next = '0;
                cb_next = col_first_reg;
                ca_next = col_rem_reg;
                if (y_last) begin
                    y_next  = '0;
                    rr_next = '0;
                    rs_next = '0;
                    rb_next = row_first_reg;
                    ra_next = row_rem_reg;
                end else begin
                    y_next = y_inc[11:0];
                    if ((rr_e < row_n_reg) && row_hit) begin
                        rr_next = rr_e + 11'd1;
                        rs_next = rb_e;
                        rb_next = nb_r.pos;
                        ra_next = nb_r.acc;
                    end
                end
            end else begin
                x_next = x_inc[11:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg  <= '0;
            y_reg  <= '0;
            rc_reg <= '0;
            rr_reg <= '0;
            cs_reg <= '0;
            cb_reg <= '0;
            ca_reg <= '0;
            rs_reg <= '0;
            rb_reg <= '0;
            ra_reg <= '0;
        end else begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            rc_reg <= rc_next;
            rr_reg <= rr_next;
            cs_reg <= cs_next;
            cb_reg <= cb_next;
            ca_reg <= ca_next;
            rs_reg <= rs_next;
            rb_reg <= rb_next;
            ra_reg <= ra_next;
        end
    end

    // Sum reads as zero on the first pixel of a region in the band's first row
    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            rd_reg    <= sums_mem[rc_e[9:0]];
            addr_reg  <= rc_e[9:0];
            zero_reg  <= ({1'b0, y_e} == rs_e) && ({1'b0, x_e} == cs_e);
            act_reg   <= active;
            emit_reg  <= active && col_hit && row_hit;
            r_reg     <= s_pixel[23:16];
            g_reg     <= s_pixel[15:8];
            b_reg     <= s_pixel[7:0];
            cnt_reg   <= cnt_full[24:0];
            ocol_reg  <= rc_e[9:0];
            orow_reg  <= rr_e[9:0];
            odone_reg <= (rc_e + 11'd1 == col_n_reg) && (rr_e + 11'd1 == row_n_reg);
        end
        if (cmd.acc && act_reg) begin
            sums_mem[addr_reg] <= {sum_r, sum_g, sum_b};
        end
    end

    assign sum_r = (zero_reg ? 32'd0 : rd_reg[95:64]) + {24'd0, r_reg};
    assign sum_g = (zero_reg ? 32'd0 : rd_reg[63:32]) + {24'd0, g_reg};
    assign sum_b = (zero_reg ? 32'd0 : rd_reg[31:0])  + {24'd0, b_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            avg_reg     <= {bavg_pkg::ALPHA, quo[0][7:0], quo[1][7:0], quo[2][7:0]};
            col_out_reg <= ocol_reg;
            row_out_reg <= orow_reg;
            odn_reg     <= odone_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_avg_pixel  = avg_reg;
    assign m_out_col    = col_out_reg;
    assign m_out_row    = row_out_reg;
    assign m_frame_done = odn_reg;

    assign sts.cfg_hit  = cfg_valid && (cfg_index <= bavg_pkg::REG_OUT_HEIGHT);
    assign sts.div_done = div_done;
    assign sts.emit     = emit_reg;
    assign sts.out_free = !m_valid_reg || m_ready;

endmodule

>>> sv/bavg_ctrl.sv
// Controller state machine: setup divisions, pixel accumulate, average and
// output hand-off. Depends on bavg_pkg.
module bavg_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  bavg_pkg::sts_t  sts,
    output bavg_pkg::cmd_t  cmd
);

    localparam logic [3:0] ST_COL_GO   = 4'd0;
    localparam logic [3:0] ST_COL_WAIT = 4'd1;
    localparam logic [3:0] ST_ROW_GO   = 4'd2;
    localparam logic [3:0] ST_ROW_WAIT = 4'd3;
    localparam logic [3:0] ST_RESTART  = 4'd4;
    localparam logic [3:0] ST_IDLE     = 4'd5;
    localparam logic [3:0] ST_ACC      = 4'd6;
    localparam logic [3:0] ST_AVG_WAIT = 4'd7;
    localparam logic [3:0] ST_OUT      = 4'd8;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_COL_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = bavg_pkg::DIV_COL;
                state_next    = ST_COL_WAIT;
            end
            ST_COL_WAIT: begin
                cmd.div_sel = bavg_pkg::DIV_COL;
                if (sts.div_done) begin
                    cmd.load_col = 1'b1;
                    state_next   = ST_ROW_GO;
                end
            end
            ST_ROW_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = bavg_pkg::DIV_ROW;
                state_next    = ST_ROW_WAIT;
            end
            ST_ROW_WAIT: begin
                cmd.div_sel = bavg_pkg::DIV_ROW;
                if (sts.div_done) begin
                    cmd.load_row = 1'b1;
                    state_next   = ST_RESTART;
                end
            end
            ST_RESTART: begin
                cmd.restart = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.step   = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.acc     = 1'b1;
                cmd.div_sel = bavg_pkg::DIV_AVG;
                if (sts.emit) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_AVG_WAIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_AVG_WAIT: begin
                cmd.div_sel = bavg_pkg::DIV_AVG;
                if (sts.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                cmd.div_sel = bavg_pkg::DIV_AVG;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_COL_GO;
            end
        endcase
        if (sts.cfg_hit) begin
            state_next = ST_COL_GO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COL_GO;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/bavg_chk.sv
// Port-level checker for the block average downscaler, bound to the top.
// Depends on block_average_downscaler_unit.
module bavg_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_avg_pixel,
    input logic [9:0]  m_out_col,
    input logic [9:0]  m_out_row,
    input logic        m_frame_done
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_avg_pixel) && $stable(m_out_col)
            && $stable(m_out_row) && $stable(m_frame_done))
        else $error("result changed while stalled");

    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_avg_pixel[31:24] == 8'hFF)
        else $error("alpha not opaque");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("pixel taken while previous one in flight");

endmodule

bind block_average_downscaler_unit bavg_chk u_bavg_chk (.*);

>>> tb/sv/block_average_downscaler_checker.sv
// Scoreboard for the block average downscaler: follows register, pixel and
// average transfers, predicts each region average and compares. Needs bavg_pkg.
module block_average_downscaler_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_pixel,
    input  logic        s_frame_start,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_avg_pixel,
    input  logic [9:0]  m_out_col,
    input  logic [9:0]  m_out_row,
    input  logic        m_frame_done,
    output int          errors,
    output int          outstanding,
    output int          averages_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] avg;
        logic [9:0]  col;
        logic [9:0]  row;
        logic        done;
    } region_avg_t;

    region_avg_t expected_avgs[$];

    bit          fit_mode;
    logic [12:0] w_src, h_src, blk_edge;
    logic [10:0] w_out, h_out;
    int unsigned red_acc[bavg_pkg::MAX_OUT_DIM];
    int unsigned green_acc[bavg_pkg::MAX_OUT_DIM];
    int unsigned blue_acc[bavg_pkg::MAX_OUT_DIM];
    int unsigned col_pos, row_pos, reg_col, reg_row, col_end, row_end;
    int          err_count = 0;
    int          check_count = 0;

    assign errors           = err_count;
    assign averages_checked = check_count;

    function automatic int unsigned src_len(bit vert);
        int unsigned v;
        v = vert ? h_src : w_src;
        if (v == 0) return 1;
        if (v > bavg_pkg::MAX_SRC_DIM) return bavg_pkg::MAX_SRC_DIM;
        return v;
    endfunction

    function automatic int unsigned blk_len();
        return (blk_edge == 0) ? 1 : blk_edge;
    endfunction

    function automatic int unsigned out_len(bit vert);
        int unsigned s, n;
        s = src_len(vert);
        if (fit_mode) begin
            n = vert ? h_out : w_out;
            if (n == 0) n = 1;
            if (n > bavg_pkg::MAX_OUT_DIM) n = bavg_pkg::MAX_OUT_DIM;
            if (n > s) n = s;
        end else begin
            n = s / blk_len();
            if (n == 0) n = 1;
            if (n > bavg_pkg::MAX_OUT_DIM) n = bavg_pkg::MAX_OUT_DIM;
        end
        return n;
    endfunction

    function automatic longint unsigned span_start(bit vert, int unsigned i);
        longint unsigned s, st;
        s = src_len(vert);
        if (fit_mode) return (longint'(i) * s) / out_len(vert);
        st = longint'(i) * blk_len();
        return (st < s) ? st : s;
    endfunction

    function automatic longint unsigned span_end(bit vert, int unsigned i);
        longint unsigned s, st, e;
        s  = src_len(vert);
        st = span_start(vert, i);
        if (fit_mode) begin
            e = (longint'(i + 1) * s) / out_len(vert);
            if (e < st + 1) e = st + 1;
        end else begin
            e = longint'(i) * blk_len() + blk_len();
            if (e > s) e = s;
        end
        return e;
    endfunction

    function automatic void clear_band();
        foreach (red_acc[k]) begin
            red_acc[k]   = 0;
            green_acc[k] = 0;
            blue_acc[k]  = 0;
        end
    endfunction

    function automatic void restart_frame();
        col_pos = 0;
        row_pos = 0;
        reg_col = 0;
        reg_row = 0;
        col_end = span_end(0, 0);
        row_end = span_end(1, 0);
        clear_band();
    endfunction

    function automatic void accumulate_pixel(logic [31:0] pix, logic fs);
        int unsigned     sw, sh, tw, th, x, y, c;
        longint unsigned cnt;
        region_avg_t     r;
        sw = src_len(0);
        sh = src_len(1);
        tw = out_len(0);
        th = out_len(1);
        if (fs) restart_frame();
        x = col_pos;
        y = row_pos;
        if (reg_row < th && reg_col < tw && reg_col < bavg_pkg::MAX_OUT_DIM) begin
            c = reg_col;
            red_acc[c]   += pix[23:16];
            green_acc[c] += pix[15:8];
            blue_acc[c]  += pix[7:0];
            if (x + 1 >= col_end) begin
                if (y + 1 >= row_end) begin
                    cnt = (span_end(0, c) - span_start(0, c))
                        * (span_end(1, reg_row) - span_start(1, reg_row));
                    if (cnt == 0) cnt = 1;
                    r.avg  = {bavg_pkg::ALPHA, 8'(red_acc[c] / cnt),
                              8'(green_acc[c] / cnt), 8'(blue_acc[c] / cnt)};
                    r.col  = 10'(c);
                    r.row  = 10'(reg_row);
                    r.done = (c + 1 == tw && reg_row + 1 == th);
                    expected_avgs.push_back(r);
                end
                reg_col++;
                if (reg_col < tw) col_end = span_end(0, reg_col);
            end
        end
        if (x + 1 >= sw) begin
            col_pos = 0;
            reg_col = 0;
            col_end = span_end(0, 0);
            if (y + 1 >= sh) begin
                row_pos = 0;
                reg_row = 0;
                row_end = span_end(1, 0);
                clear_band();
            end else begin
                row_pos = y + 1;
                if (reg_row < th && y + 1 >= row_end) begin
                    reg_row++;
                    clear_band();
                    if (reg_row < th) row_end = span_end(1, reg_row);
                end
            end
        end else begin
            col_pos = x + 1;
        end
    endfunction

    function automatic void write_setting(logic [2:0] idx, logic [12:0] val);
        case (idx)
            bavg_pkg::REG_MODE:       fit_mode = val[0];
            bavg_pkg::REG_SRC_WIDTH:  w_src    = val;
            bavg_pkg::REG_SRC_HEIGHT: h_src    = val;
            bavg_pkg::REG_BLOCK_SIZE: blk_edge = val;
            bavg_pkg::REG_OUT_WIDTH:  w_out    = val[10:0];
            bavg_pkg::REG_OUT_HEIGHT: h_out    = val[10:0];
            default:                  return;
        endcase
        restart_frame();
    endfunction

    function automatic void compare_avg();
        region_avg_t e;
        if (expected_avgs.size() == 0) begin
            err_count++;
            $display("%0t: unexpected average %h col %0d row %0d done %0d", $time,
                     m_avg_pixel, m_out_col, m_out_row, m_frame_done);
            return;
        end
        e = expected_avgs.pop_front();
        check_count++;
        if (m_avg_pixel !== e.avg) begin
            err_count++;
            $display("%0t: avg_pixel expected %h actual %h", $time, e.avg, m_avg_pixel);
        end
        if (m_out_col !== e.col) begin
            err_count++;
            $display("%0t: out_col expected %0d actual %0d", $time, e.col, m_out_col);
        end
        if (m_out_row !== e.row) begin
            err_count++;
            $display("%0t: out_row expected %0d actual %0d", $time, e.row, m_out_row);
        end
        if (m_frame_done !== e.done) begin
            err_count++;
            $display("%0t: frame_done expected %0d actual %0d", $time, e.done,
                     m_frame_done);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode = 1'b0;
            w_src    = 13'd1;
            h_src    = 13'd1;
            blk_edge = 13'd1;
            w_out    = 11'd1;
            h_out    = 11'd1;
            restart_frame();
            expected_avgs.delete();
        end else begin
            if (m_valid && m_ready) compare_avg();
            if (cfg_valid && cfg_ready) write_setting(cfg_index, cfg_data);
            if (s_valid && s_ready) accumulate_pixel(s_pixel, s_frame_start);
        end
        outstanding <= expected_avgs.size();
    end
endmodule

>>> tb/sv/block_average_downscaler_unit_test.sv
// Testbench top for the block average downscaler: clock, reset, register
// writes and pixel frames. Needs bavg_pkg, the block and its checker.
module block_average_downscaler_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT     = 3_000_000;
    localparam int TAIL      = 120;
    localparam int HOLD_LEN  = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = bavg_pkg::REG_MODE;
    logic [12:0] cfg_data = 13'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_pixel = 32'd0;
    logic        s_frame_start = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_avg_pixel;
    logic [9:0]  m_out_col;
    logic [9:0]  m_out_row;
    logic        m_frame_done;

    int errors, outstanding, averages_checked;
    int cycles = 0;
    int pixels_sent = 0;
    int settings_used = 0;
    bit gaps_on = 1'b1;
    int hold_tokens = 0;
    int hold_served = 0;
    int hold_left = 0;

    block_average_downscaler_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pixel(s_pixel), .s_frame_start(s_frame_start),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_avg_pixel(m_avg_pixel), .m_out_col(m_out_col),
        .m_out_row(m_out_row), .m_frame_done(m_frame_done)
    );

    block_average_downscaler_checker avg_check (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pixel(s_pixel), .s_frame_start(s_frame_start),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_avg_pixel(m_avg_pixel), .m_out_col(m_out_col),
        .m_out_row(m_out_row), .m_frame_done(m_frame_done),
        .errors(errors), .outstanding(outstanding),
        .averages_checked(averages_checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("block_average_downscaler_unit_test: errors");
            $finish;
        end
    end

    // hold off the result side on request, otherwise stall at random while gaps are on
    always @(posedge aclk) begin
        if (hold_tokens != hold_served) begin
            hold_served = hold_tokens;
            hold_left   = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= gaps_on ? ($urandom_range(99) >= 11) : 1'b1;
        end
    end

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (TAIL) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [12:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(bit m, int sw, int sh, int bs, int ow, int oh);
        drain();
        write_reg(bavg_pkg::REG_MODE, 13'(m));
        write_reg(bavg_pkg::REG_SRC_WIDTH, 13'(sw));
        write_reg(bavg_pkg::REG_SRC_HEIGHT, 13'(sh));
        write_reg(bavg_pkg::REG_BLOCK_SIZE, 13'(bs));
        write_reg(bavg_pkg::REG_OUT_WIDTH, 13'(ow));
        write_reg(bavg_pkg::REG_OUT_HEIGHT, 13'(oh));
        settings_used++;
    endtask

    task automatic send(logic [31:0] pix, logic fs);
        if (gaps_on && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel       <= pix;
        s_frame_start <= fs;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
    endtask

    // one frame of random pixels; a broken frame restarts early or is cut short
    task automatic send_frame(int sw, int sh, bit broken);
        int n;
        n = ((sw == 0) ? 1 : sw) * ((sh == 0) ? 1 : sh);
        for (int i = 0; i < n; i++) begin
            if (broken && i > 0 && $urandom_range(99) < 4) break;
            send($urandom, (i == 0) || (broken && $urandom_range(99) < 3));
        end
    endtask

    initial begin
        int sw, sh;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        configure(0, 3, 2, 2, 1, 1);
        send(32'h0000_0000, 1'b1);
        send(32'hFFFF_FFFF, 1'b0);
        send(32'hFFFF_FFFF, 1'b0);
        send(32'h00FF_00FF, 1'b0);
        send(32'hFF00_FF00, 1'b0);
        send(32'h0000_0000, 1'b0);
        for (int i = 0; i < 6; i++) send($urandom, 1'b0);
        configure(1, 3, 2, 0, 0, 5);
        for (int i = 0; i < 4; i++) send($urandom, i == 0);
        for (int i = 0; i < 6; i++) send($urandom, i == 0);

        for (int phase = 0; pixels_sent < 760; phase++) begin
            gaps_on <= !(phase >= 6 && phase < 10);
            if (phase == 3) begin
                configure(0, 8, 4, 1, 1, 1);
                hold_tokens <= hold_tokens + 1;
                send_frame(8, 4, 1'b0);
                send_frame(8, 4, 1'b0);
                continue;
            end
            sw = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 9);
            sh = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 9);
            configure(1'($urandom_range(1)), sw, sh, $urandom_range(0, 11),
                      $urandom_range(0, 11), $urandom_range(0, 11));
            repeat ($urandom_range(1, 3)) send_frame(sw, sh, $urandom_range(99) < 15);
        end

        gaps_on <= 1'b1;
        configure(0, 8191, 1, 1, 1, 1);
        send_frame(48, 1, 1'b0);
        configure(1, 1100, 2, 1, 2047, 1);
        send_frame(48, 1, 1'b0);
        configure(0, 1, 12, 4096, 1, 1);
        send_frame(1, 12, 1'b0);
        configure(1, 1, 1030, 0, 1, 1024);
        send_frame(1, 40, 1'b0);
        configure(0, 2, 2, 4096, 0, 0);
        send_frame(2, 2, 1'b0);

        drain();
        $display("Sent %0d pixels under %0d register settings, checked %0d averages",
                 pixels_sent, settings_used, averages_checked);
        if (errors == 0) begin
            $display("block_average_downscaler_unit_test: clean");
        end else begin
            $display("block_average_downscaler_unit_test: errors");
        end
        $finish;
    end
endmodule
